@@ design/rsl_pkg.sv @@
// Range sensor linearizer package: status and register codes, field widths,
// calibration table and per-segment interpolation constants.
// No dependencies.
package rsl_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int DIST_W        = 11;
    localparam int LEVEL_W       = 10;
    localparam int STORED_POINTS = 17;
    localparam int TABLE_POINTS  = 17;
    localparam int SEG_IW        = 4;   // index over the 16 stored segments
    localparam int OFF_W         = 7;   // sample offset inside a segment, widest span 72
    localparam int DROP_W        = 7;   // distance drop over a segment, at most 100
    localparam int PROD_W        = 14;  // drop * offset
    localparam int RECIP_W       = 18;
    localparam int RECIP_SHIFT   = 20;

    localparam logic [LEVEL_W-1:0] DISC_RESET = 10'd30;
    localparam logic [LEVEL_W-1:0] FAR_RESET  = 10'd92;
    localparam logic [LEVEL_W-1:0] NEAR_RESET = 10'd512;

    localparam logic [DIST_W-1:0] DIST_MIN = 11'd200;
    localparam logic [DIST_W-1:0] DIST_MAX = 11'd1500;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CLOSE = 2'd1,
        ST_FAR   = 2'd2,
        ST_DISC  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_DISC = 2'd0,
        REG_FAR  = 2'd1,
        REG_NEAR = 2'd2
    } t_reg_idx;

    // calibration points: rising converter codes, falling distances
    localparam logic [SAMPLE_W-1:0] CAL_CODE [STORED_POINTS] = '{
        10'd92,  10'd98,  10'd106, 10'd115, 10'd123, 10'd133, 10'd147, 10'd164,
        10'd180, 10'd205, 10'd235, 10'd262, 10'd297, 10'd327, 10'd368, 10'd440,
        10'd512
    };

    localparam logic [DIST_W-1:0] CAL_TENTHS [STORED_POINTS] = '{
        11'd1500, 11'd1400, 11'd1300, 11'd1200, 11'd1100, 11'd1000, 11'd900,
        11'd800,  11'd700,  11'd600,  11'd500,  11'd450,  11'd400,  11'd350,
        11'd300,  11'd250,  11'd200
    };

    // tenths(i) - tenths(i+1)
    localparam logic [DROP_W-1:0] SEG_DROP [STORED_POINTS-1] = '{
        7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
        7'd100, 7'd100, 7'd50,  7'd50,  7'd50,  7'd50,  7'd50,  7'd50
    };

    // ceil(2^20 / span). Exact floor quotient for drop*offset < 4096 since
    // the rounding error times the dividend stays below 2^20.
    // A zero-width segment would carry 0 here and yield the start distance.
    localparam logic [RECIP_W-1:0] SEG_RECIP [STORED_POINTS-1] = '{
        18'd174763, 18'd131072, 18'd116509, 18'd131072,
        18'd104858, 18'd74899,  18'd61681,  18'd65536,
        18'd41944,  18'd34953,  18'd38837,  18'd29960,
        18'd34953,  18'd25576,  18'd14564,  18'd14564
    };

endpackage

@@ design/rsl_sample_if.sv @@
// Input channel of the range sensor linearizer: one converter sample per transaction.
// Depends on rsl_pkg for the field width.
interface rsl_sample_if;
    logic                          valid;
    logic                          ready;
    logic [rsl_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ design/rsl_result_if.sv @@
// Output channel of the range sensor linearizer: status and distance per transaction.
// Depends on rsl_pkg for the field widths.
interface rsl_result_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [rsl_pkg::DIST_W-1:0]  distance;

    modport source (output valid, output status, output distance, input ready);
    modport sink   (input valid, input status, input distance, output ready);
endinterface

@@ design/range_sensor_linearizer_unit.sv @@
// Range sensor linearizer: raw 10-bit sample in, status and distance
// (tenths of a cm) out, by piecewise-linear interpolation over a constant
// calibration table. Depends on rsl_pkg, rsl_sample_if and rsl_result_if.
//
// Usage:
//   i_smp  : valid/ready sample channel, one sample per transaction.
//   o_res  : valid/ready result channel, exactly one result per sample,
//            in order. distance is 0 unless status is ok.
//   APB    : three 10-bit level registers at 0x0 (disconnect), 0x4 (far),
//            0x8 (near). Write only while no sample is in flight.
// Pipeline: five register stages; the edge that takes the sample loads the
//   first, and o_res.valid rises once the sample reaches the fifth.
//   Throughput: one transaction per cycle unless o_res.ready stalls a full
//   pipeline; the two multiplies of the reciprocal divider each fit in a stage.
// Reset (synchronous, active low) empties the pipeline and loads the
//   levels with 30 / 92 / 512.
// Stall: when o_res.ready is low, the pipeline keeps filling its empty
//   stages; i_smp.ready drops only once every stage holds a sample.
module range_sensor_linearizer_unit #(
    parameter int TABLE_POINTS = rsl_pkg::TABLE_POINTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rsl_sample_if.sink                i_smp,
    rsl_result_if.source              o_res,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // segments searched: among the first TABLE_POINTS stored points
    localparam int NPTS = (TABLE_POINTS < rsl_pkg::STORED_POINTS) ?
                          TABLE_POINTS : rsl_pkg::STORED_POINTS;
    localparam int SEGS = NPTS - 1;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [rsl_pkg::LEVEL_W-1:0] r_disc, r_far, r_near;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc <= rsl_pkg::DISC_RESET;
            r_far  <= rsl_pkg::FAR_RESET;
            r_near <= rsl_pkg::NEAR_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                rsl_pkg::REG_DISC: r_disc <= pwdata[rsl_pkg::LEVEL_W-1:0];
                rsl_pkg::REG_FAR:  r_far  <= pwdata[rsl_pkg::LEVEL_W-1:0];
                rsl_pkg::REG_NEAR: r_near <= pwdata[rsl_pkg::LEVEL_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rsl_pkg::REG_DISC: prdata = {22'd0, r_disc};
            rsl_pkg::REG_FAR:  prdata = {22'd0, r_far};
            rsl_pkg::REG_NEAR: prdata = {22'd0, r_near};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline flow control: a stage loads when it is empty or its
    // successor loads, so bubbles collapse under a stall
    // ---------------------------------------------------------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r5_v || o_res.ready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_smp.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_smp.valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: level checks and per-segment span compares
    // ---------------------------------------------------------------
    rsl_pkg::t_status             n1_st;
    logic [SEGS-1:0]              n1_hit;
    rsl_pkg::t_status             r1_st;
    logic [SEGS-1:0]              r1_hit;
    logic [rsl_pkg::SAMPLE_W-1:0] r1_smp;

    always_comb begin
        priority if (i_smp.sample < r_disc) begin
            n1_st = rsl_pkg::ST_DISC;
        end else if (i_smp.sample < r_far) begin
            n1_st = rsl_pkg::ST_FAR;
        end else if (i_smp.sample > r_near) begin
            n1_st = rsl_pkg::ST_CLOSE;
        end else begin
            n1_st = rsl_pkg::ST_OK;  // still needs a segment
        end
        for (int k = 0; k < SEGS; k++) begin
            n1_hit[k] = (i_smp.sample >= rsl_pkg::CAL_CODE[k]) &&
                        (i_smp.sample <= rsl_pkg::CAL_CODE[k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_st  <= n1_st;
            r1_hit <= n1_hit;
            r1_smp <= i_smp.sample;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: first matching segment, table lookup, offset in segment
    // ---------------------------------------------------------------
    logic [rsl_pkg::SEG_IW-1:0]   seg;
    logic [rsl_pkg::SAMPLE_W-1:0] off_full;
    rsl_pkg::t_status             n2_st;
    rsl_pkg::t_status             r2_st;
    logic [rsl_pkg::OFF_W-1:0]    r2_off;
    logic [rsl_pkg::DROP_W-1:0]   r2_drop;
    logic [rsl_pkg::RECIP_W-1:0]  r2_recip;
    logic [rsl_pkg::DIST_W-1:0]   r2_d0;

    always_comb begin
        seg = '0;
        for (int k = SEGS - 1; k >= 0; k--) begin
            if (r1_hit[k]) seg = rsl_pkg::SEG_IW'(k);
        end
        off_full = r1_smp - rsl_pkg::CAL_CODE[{1'b0, seg}];
        // inside the level window but outside the table: too far
        n2_st = (r1_st == rsl_pkg::ST_OK && !(|r1_hit)) ? rsl_pkg::ST_FAR : r1_st;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_st    <= n2_st;
            r2_off   <= off_full[rsl_pkg::OFF_W-1:0];
            r2_drop  <= rsl_pkg::SEG_DROP[seg];
            r2_recip <= rsl_pkg::SEG_RECIP[seg];
            r2_d0    <= rsl_pkg::CAL_TENTHS[{1'b0, seg}];
        end
    end

    // ---------------------------------------------------------------
    // stage 3: dividend = drop * offset
    // ---------------------------------------------------------------
    rsl_pkg::t_status             r3_st;
    logic [rsl_pkg::PROD_W-1:0]   r3_x;
    logic [rsl_pkg::RECIP_W-1:0]  r3_recip;
    logic [rsl_pkg::DIST_W-1:0]   r3_d0;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_st    <= r2_st;
            r3_x     <= rsl_pkg::PROD_W'(r2_drop * r2_off);
            r3_recip <= r2_recip;
            r3_d0    <= r2_d0;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: quotient by reciprocal multiply and shift
    // ---------------------------------------------------------------
    localparam int QP_W = rsl_pkg::PROD_W + rsl_pkg::RECIP_W;

    logic [QP_W-1:0]              qprod;
    rsl_pkg::t_status             r4_st;
    logic [rsl_pkg::DROP_W-1:0]   r4_q;
    logic [rsl_pkg::DIST_W-1:0]   r4_d0;

    assign qprod = QP_W'(r3_x) * QP_W'(r3_recip);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_st <= r3_st;
            // quotient never exceeds the segment drop for a sample inside the table
            r4_q  <= qprod[rsl_pkg::RECIP_SHIFT +: rsl_pkg::DROP_W];
            r4_d0 <= r3_d0;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: output register
    // ---------------------------------------------------------------
    rsl_pkg::t_status             r5_st;
    logic [rsl_pkg::DIST_W-1:0]   r5_dist;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_st   <= r4_st;
            r5_dist <= (r4_st == rsl_pkg::ST_OK) ?
                       (r4_d0 - rsl_pkg::DIST_W'(r4_q)) : '0;
        end
    end

    assign o_res.valid    = r5_v;
    assign o_res.status   = r5_st;
    assign o_res.distance = r5_dist;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_dist_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_v && r5_st != rsl_pkg::ST_OK) |-> (r5_dist == '0))
        else $error("nonzero distance with status other than ok");

    a_dist_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_v && r5_st == rsl_pkg::ST_OK) |->
        (r5_dist >= rsl_pkg::DIST_MIN && r5_dist <= rsl_pkg::DIST_MAX))
        else $error("interpolated distance outside calibration range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> (r1_v && r2_v && r3_v && r4_v && r5_v && !o_res.ready))
        else $error("input stalled while pipeline has room");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !(r1_v || r2_v || r3_v || r4_v || r5_v))
        else $error("pipeline not empty after reset");

endmodule

@@ dv/range_sensor_linearizer_unit_test.sv @@
// Self-checking testbench for range_sensor_linearizer_unit: directed and random samples,
// APB level programming, and a scoreboard fed by an internal predictor of the linearizer.
// Depends on rsl_pkg, rsl_sample_if, rsl_result_if and the unit itself.
`timescale 1ns / 100ps

module range_sensor_linearizer_unit_test;

    localparam int CLK_HALF    = 4;       // 8 ns period
    localparam int RESET_CYCLES = 12;
    localparam int PIPE_DEPTH  = 5;       // register stages between sample and result
    localparam int CYCLE_LIMIT = 400000;  // generous watchdog, slowest run is far below
    localparam int IDLE_PCT    = 31;      // chance of an idle cycle on either channel
    localparam int NUM_PHASES  = 9;
    localparam int CURVE_PTS   = 17;

    // Calibration curve used by the predictor: rising codes, falling tenths of cm.
    localparam int CURVE_CODE [CURVE_PTS] = '{
        92, 98, 106, 115, 123, 133, 147, 164, 180, 205, 235, 262, 297, 327, 368, 440, 512
    };
    localparam int CURVE_TENTHS [CURVE_PTS] = '{
        1500, 1400, 1300, 1200, 1100, 1000, 900, 800, 700, 600, 500, 450, 400, 350, 300,
        250, 200
    };

    // One expected result, tagged with the sample that caused it for messages.
    typedef struct packed {
        logic [rsl_pkg::SAMPLE_W-1:0] sample;
        rsl_pkg::t_status             status;
        logic [rsl_pkg::DIST_W-1:0]   distance;
    } t_reading;

    // Directed probe: the expectation is typed in where it is obvious (known = 1),
    // otherwise the predictor supplies it.
    typedef struct packed {
        logic [rsl_pkg::SAMPLE_W-1:0] sample;
        logic                         known;
        rsl_pkg::t_status             status;
        logic [rsl_pkg::DIST_W-1:0]   distance;
    } t_probe;

    localparam int N_PROBES = 16;
    // All rows run with the reset levels 30 / 92 / 512.
    localparam t_probe DIRECTED_PROBES [N_PROBES] = '{
        '{10'd0,    1'b1, rsl_pkg::ST_DISC,  11'd0},     // lowest code
        '{10'd29,   1'b1, rsl_pkg::ST_DISC,  11'd0},     // just under disconnect level
        '{10'd30,   1'b1, rsl_pkg::ST_FAR,   11'd0},     // on disconnect level -> far
        '{10'd91,   1'b1, rsl_pkg::ST_FAR,   11'd0},     // just under far level
        '{10'd92,   1'b1, rsl_pkg::ST_OK,    11'd1500},  // first curve point
        '{10'd98,   1'b1, rsl_pkg::ST_OK,    11'd1400},  // segment joint
        '{10'd95,   1'b0, rsl_pkg::ST_OK,    11'd0},
        '{10'd150,  1'b0, rsl_pkg::ST_OK,    11'd0},
        '{10'd341,  1'b0, rsl_pkg::ST_OK,    11'd0},     // alternating bit pattern
        '{10'd440,  1'b1, rsl_pkg::ST_OK,    11'd250},   // joint of the widest segment
        '{10'd441,  1'b0, rsl_pkg::ST_OK,    11'd0},
        '{10'd512,  1'b1, rsl_pkg::ST_OK,    11'd200},   // last curve point, on near level
        '{10'd513,  1'b1, rsl_pkg::ST_CLOSE, 11'd0},     // just over near level
        '{10'd682,  1'b1, rsl_pkg::ST_CLOSE, 11'd0},     // alternating bit pattern
        '{10'd700,  1'b1, rsl_pkg::ST_CLOSE, 11'd0},
        '{10'd1023, 1'b1, rsl_pkg::ST_CLOSE, 11'd0}      // highest code
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rsl_sample_if smp_bus ();
    rsl_result_if res_bus ();

    range_sensor_linearizer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the level registers.
    logic [rsl_pkg::LEVEL_W-1:0] lvl_disc;
    logic [rsl_pkg::LEVEL_W-1:0] lvl_far;
    logic [rsl_pkg::LEVEL_W-1:0] lvl_near;

    t_reading pending_readings [$];   // expected results, oldest first
    bit       quiet;                  // when set, neither side idles
    int       mismatches;
    int       items_sent;
    int       results_checked;
    int       cycle_count;
    int       status_tally [4];
    int       settings_used;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_readings.size());
            $display("range_sensor_linearizer_unit_test: FAIL");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Predictor: level checks in priority order, then first segment holding the
    // sample, truncating interpolation. No segment found leaves status far.
    function automatic t_reading linearize(input logic [rsl_pkg::SAMPLE_W-1:0] s);
        t_reading r;
        int       npts;
        int       i;
        int       a0;
        int       a1;
        int       d0;
        int       d1;
        r.sample   = s;
        r.status   = rsl_pkg::ST_FAR;
        r.distance = '0;
        npts = (rsl_pkg::TABLE_POINTS < CURVE_PTS) ? rsl_pkg::TABLE_POINTS : CURVE_PTS;
        if (s < lvl_disc) begin
            r.status = rsl_pkg::ST_DISC;
        end else if (s < lvl_far) begin
            r.status = rsl_pkg::ST_FAR;
        end else if (s > lvl_near) begin
            r.status = rsl_pkg::ST_CLOSE;
        end else begin
            for (i = 0; i + 1 < npts; i++) begin
                a0 = CURVE_CODE[i];
                a1 = CURVE_CODE[i + 1];
                if (int'(s) >= a0 && int'(s) <= a1) begin
                    d0 = CURVE_TENTHS[i];
                    d1 = CURVE_TENTHS[i + 1];
                    r.status = rsl_pkg::ST_OK;
                    if (a1 == a0)
                        r.distance = rsl_pkg::DIST_W'(d0);
                    else
                        r.distance = rsl_pkg::DIST_W'(
                            d0 - ((d0 - d1) * (int'(s) - a0)) / (a1 - a0));
                    break;
                end
            end
        end
        return r;
    endfunction

    // Random sample, weighted toward the curve, its joints and the level edges.
    function automatic logic [rsl_pkg::SAMPLE_W-1:0] pick_sample();
        int v;
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            v = $urandom_range(1023);
        end else if (roll < 65) begin
            v = $urandom_range(512, 92);
        end else if (roll < 80) begin
            v = CURVE_CODE[$urandom_range(CURVE_PTS - 1)] + $urandom_range(2) - 1;
        end else begin
            case ($urandom_range(2))
                0:       v = lvl_disc;
                1:       v = lvl_far;
                default: v = lvl_near;
            endcase
            v = v + $urandom_range(4) - 2;
        end
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return rsl_pkg::SAMPLE_W'(v);
    endfunction

    // One sample transaction; the expectation is queued at the accepting edge.
    task automatic send_sample(input logic [rsl_pkg::SAMPLE_W-1:0] s, input t_reading want);
        bit idle;
        forever begin
            @(negedge i_clk);
            idle = !quiet && ($urandom_range(99) < IDLE_PCT);
            if (!idle) break;
            smp_bus.valid = 1'b0;
        end
        smp_bus.valid  = 1'b1;
        smp_bus.sample = s;
        do @(posedge i_clk); while (!smp_bus.ready);
        pending_readings.push_back(want);
        items_sent++;
    endtask

    // Stop sending and wait until every outstanding result has been checked.
    task automatic drain_results();
        @(negedge i_clk);
        smp_bus.valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // APB read of one level register, compared with the expected 10-bit value.
    task automatic check_level(input rsl_pkg::t_reg_idx idx,
                               input logic [rsl_pkg::LEVEL_W-1:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== {22'd0, want})
            flag_mismatch($sformatf("%s reads 0x%0h, expected 0x%0h",
                                    idx.name(), got, want));
    endtask

    // APB write; only the low 10 bits count, the rest may carry junk.
    task automatic set_level(input rsl_pkg::t_reg_idx idx, input logic [31:0] word);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            rsl_pkg::REG_DISC: lvl_disc = word[rsl_pkg::LEVEL_W-1:0];
            rsl_pkg::REG_FAR:  lvl_far  = word[rsl_pkg::LEVEL_W-1:0];
            rsl_pkg::REG_NEAR: lvl_near = word[rsl_pkg::LEVEL_W-1:0];
            default: ;
        endcase
        check_level(idx, word[rsl_pkg::LEVEL_W-1:0]);
    endtask

    task automatic apply_levels(input int d, input int f, input int n, input bit junk);
        logic [31:0] hi;
        hi = junk ? ($urandom() & 32'hFFFF_FC00) : 32'd0;
        set_level(rsl_pkg::REG_DISC, hi | 32'(d));
        set_level(rsl_pkg::REG_FAR,  hi | 32'(f));
        set_level(rsl_pkg::REG_NEAR, hi | 32'(n));
        settings_used++;
    endtask

    // Result side: random back-pressure, applied at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n)
            res_bus.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Scoreboard: every result transaction against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_reading want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            status_tally[res_bus.status]++;
            if (pending_readings.size() == 0) begin
                flag_mismatch($sformatf("unexpected result status %0d distance %0d",
                                        res_bus.status, res_bus.distance));
            end else begin
                want = pending_readings.pop_front();
                results_checked++;
                if (res_bus.status !== want.status)
                    flag_mismatch($sformatf("sample %0d: status %0d, expected %s",
                                            want.sample, res_bus.status,
                                            want.status.name()));
                if (res_bus.distance !== want.distance)
                    flag_mismatch($sformatf("sample %0d: distance %0d, expected %0d",
                                            want.sample, res_bus.distance,
                                            want.distance));
            end
        end
    end

    initial begin : stimulus
        int       ph;
        int       k;
        int       d;
        int       f;
        int       n;
        int       cnt;
        bit       junk;
        t_reading want;

        // Every input known from time zero, reset asserted.
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        smp_bus.valid  = 1'b0;
        smp_bus.sample = '0;
        res_bus.ready  = 1'b0;
        quiet          = 1'b0;
        lvl_disc       = 10'd30;
        lvl_far        = 10'd92;
        lvl_near       = 10'd512;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Levels must come up at their reset values.
        check_level(rsl_pkg::REG_DISC, 10'd30);
        check_level(rsl_pkg::REG_FAR,  10'd92);
        check_level(rsl_pkg::REG_NEAR, 10'd512);

        // Directed probes under the reset levels.
        for (k = 0; k < N_PROBES; k++) begin
            if (DIRECTED_PROBES[k].known) begin
                want.sample   = DIRECTED_PROBES[k].sample;
                want.status   = DIRECTED_PROBES[k].status;
                want.distance = DIRECTED_PROBES[k].distance;
            end else begin
                want = linearize(DIRECTED_PROBES[k].sample);
            end
            send_sample(DIRECTED_PROBES[k].sample, want);
        end

        // Random phases, each under its own level setting. Levels change only
        // once the pipe has drained, which also pauses the sender each time.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            junk = 1'b0;
            case (ph)
                0: begin d = 30;   f = 92;   n = 512;  cnt = 180; end  // no idling here
                1: begin d = 0;    f = 0;    n = 1023; cnt = 100; end  // off-curve -> far
                2: begin d = 1023; f = 1023; n = 0;    cnt = 50;  end  // all levels crossed
                3: begin d = 1023; f = 0;    n = 1023; cnt = 40;  end
                4, 5, 6: begin
                    d = $urandom_range(1023);
                    f = $urandom_range(1023);
                    n = $urandom_range(1023);
                    cnt = 90;
                end
                7: begin                                                // ordered, on-curve
                    f = $urandom_range(300, 92);
                    d = $urandom_range(f);
                    n = $urandom_range(512, f);
                    cnt = 110;
                end
                default: begin d = 30; f = 92; n = 512; cnt = 100; junk = 1'b1; end
            endcase
            drain_results();
            apply_levels(d, f, n, junk);
            quiet = (ph == 0);
            for (k = 0; k < cnt; k++) begin
                // mid-phase hold-off: let the whole pipe empty before continuing
                if (ph == NUM_PHASES - 1 && k == cnt / 2)
                    drain_results();
                want = linearize(pick_sample());
                send_sample(want.sample, want);
            end
            quiet = 1'b0;
        end

        drain_results();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);

        $display("covered %0d samples over %0d level settings, %0d results checked",
                 items_sent, settings_used + 1, results_checked);
        $display("status mix: ok %0d, close %0d, far %0d, disconnected %0d",
                 status_tally[rsl_pkg::ST_OK], status_tally[rsl_pkg::ST_CLOSE],
                 status_tally[rsl_pkg::ST_FAR], status_tally[rsl_pkg::ST_DISC]);
        if (mismatches == 0) begin
            $display("range_sensor_linearizer_unit_test: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("range_sensor_linearizer_unit_test: FAIL");
        end
        $finish;
    end

endmodule

@@ range_sensor_linearizer_unit.f @@
design/rsl_pkg.sv
design/rsl_sample_if.sv
design/rsl_result_if.sv
design/range_sensor_linearizer_unit.sv
dv/range_sensor_linearizer_unit_test.sv
